@@ src/pcpf_pkg.sv @@
package pcpf_pkg;

  // default sizes of the site store and of the item fields
  localparam int MAX_SITES_DEF    = 64;
  localparam int COORD_BITS_DEF   = 24;
  localparam int RESIDUE_BITS_DEF = 16;

  // distance register and its square
  localparam int DIST_BITS = 16;
  localparam int SQ_BITS   = 2 * DIST_BITS;
  localparam logic [DIST_BITS-1:0] MAX_DIST_RESET = 16'd640;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FLUSH
  } pcpf_state_e;

  // tag that follows one store read down the distance pipeline
  typedef struct packed {
    logic valid;
    logic last;
  } pcpf_tag_t;

  // verdict for one stored site
  typedef struct packed {
    logic valid;
    logic match;
    logic last;
  } pcpf_hit_t;

endpackage

@@ src/pcpf_site_mem.sv @@
module pcpf_site_mem
  import pcpf_pkg::*;
#(
  parameter int DEPTH = MAX_SITES_DEF,
  parameter int WIDTH = RESIDUE_BITS_DEF + 3 * COORD_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // one read port, data registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/pcpf_dist_pipe.sv @@
module pcpf_dist_pipe
  import pcpf_pkg::*;
#(
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int RESIDUE_BITS = RESIDUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pcpf_tag_t                      req_i,
  input  logic        [RESIDUE_BITS-1:0] site_res_i,
  input  logic signed [COORD_BITS-1:0]   site_x_i,
  input  logic signed [COORD_BITS-1:0]   site_y_i,
  input  logic signed [COORD_BITS-1:0]   site_z_i,
  input  logic signed [COORD_BITS-1:0]   new_x_i,
  input  logic signed [COORD_BITS-1:0]   new_y_i,
  input  logic signed [COORD_BITS-1:0]   new_z_i,
  input  logic        [SQ_BITS-1:0]      lim_i,
  output pcpf_hit_t                      hit_o,
  output logic        [RESIDUE_BITS-1:0] hit_res_o
);

  // difference width: one bit over the coordinates, at least enough to see 65535
  localparam int AW = (COORD_BITS + 1 > DIST_BITS + 1) ? COORD_BITS + 1 : DIST_BITS + 1;
  localparam int SUM_BITS = SQ_BITS + 2;

  pcpf_tag_t tag0_q, tag1_q, tag2_q;
  pcpf_hit_t hit_q;

  logic signed [AW-1:0] dx, dy, dz;
  logic        [AW-1:0] ax, ay, az;
  logic                 far;

  logic [DIST_BITS-1:0]    ax_q, ay_q, az_q;
  logic                    far1_q, far2_q;
  logic [RESIDUE_BITS-1:0] res1_q, res2_q, res3_q;
  logic [SQ_BITS-1:0]      sx_q, sy_q, sz_q;
  logic [SUM_BITS-1:0]     sum;

  // tags line up with the registered store data, then follow each stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag0_q <= '0;
      tag1_q <= '0;
      tag2_q <= '0;
      hit_q  <= '0;
    end else begin
      tag0_q      <= req_i;
      tag1_q      <= tag0_q;
      tag2_q      <= tag1_q;
      hit_q.valid <= tag2_q.valid;
      hit_q.last  <= tag2_q.last;
      hit_q.match <= tag2_q.valid && !far2_q && (sum <= SUM_BITS'(lim_i));
    end
  end

  // axis differences and magnitudes
  always_comb begin
    dx  = AW'(new_x_i) - AW'(site_x_i);
    dy  = AW'(new_y_i) - AW'(site_y_i);
    dz  = AW'(new_z_i) - AW'(site_z_i);
    ax  = dx[AW-1] ? AW'(-dx) : AW'(dx);
    ay  = dy[AW-1] ? AW'(-dy) : AW'(dy);
    az  = dz[AW-1] ? AW'(-dz) : AW'(dz);
    far = (|ax[AW-1:DIST_BITS]) || (|ay[AW-1:DIST_BITS]) || (|az[AW-1:DIST_BITS]);
  end

  // stage 1: magnitudes, stage 2: squares
  always_ff @(posedge clk_i) begin
    ax_q   <= ax[DIST_BITS-1:0];
    ay_q   <= ay[DIST_BITS-1:0];
    az_q   <= az[DIST_BITS-1:0];
    far1_q <= far;
    res1_q <= site_res_i;
    sx_q   <= ax_q * ax_q;
    sy_q   <= ay_q * ay_q;
    sz_q   <= az_q * az_q;
    far2_q <= far1_q;
    res2_q <= res1_q;
    res3_q <= res2_q;
  end

  // stage 3: squared distance against the limit
  assign sum = SUM_BITS'(sx_q) + SUM_BITS'(sy_q) + SUM_BITS'(sz_q);

  assign hit_o     = hit_q;
  assign hit_res_o = res3_q;

endmodule

@@ src/pairwise_contact_pair_finder.sv @@
// Contact pair finder over a stream of atom items.
// Input: an item is taken at a clock edge with start high and busy low.
// Config: cfg_we_i writes max_distance (1/256 angstrom); write it only while
//   busy is low. Reset value is 640.
// Output: each pair shows for one cycle with strobe_o high; the receiver
//   cannot stall the output.
// An item that is not a new site (not qualifying, or a repeat of the residue
//   just taken) never raises busy and the next item may follow at once.
// A new site with N sites stored keeps busy high through the scan, N reads of
//   the single read port of the site memory, the drain of the distance
//   pipeline, and the flush that releases the final pair. The next item can
//   be taken once busy falls. With no sites stored busy stays low.
// Pairs of one site come in store order and the last carries run_last_o.
//   A site met with a full store is compared but not stored, and its pairs
//   carry overflow_o.
// The end_of_structure item is handled as any other, then the store empties.
// Reset empties the store and restores the distance; the memory itself is
//   not cleared, only the fill count.
module pairwise_contact_pair_finder
  import pcpf_pkg::*;
#(
  parameter int MAX_SITES    = MAX_SITES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF,
  parameter int RESIDUE_BITS = RESIDUE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic        [RESIDUE_BITS-1:0] residue_index_i,
  input  logic                           qualifies_i,
  input  logic signed [COORD_BITS-1:0]   x_pos_i,
  input  logic signed [COORD_BITS-1:0]   y_pos_i,
  input  logic signed [COORD_BITS-1:0]   z_pos_i,
  input  logic                           end_of_structure_i,
  input  logic                           cfg_we_i,
  input  logic        [DIST_BITS-1:0]    cfg_wdata_i,
  output logic                           strobe_o,
  output logic        [RESIDUE_BITS-1:0] first_residue_o,
  output logic        [RESIDUE_BITS-1:0] second_residue_o,
  output logic                           run_last_o,
  output logic                           overflow_o
);

  localparam int IDX_W = $clog2(MAX_SITES);
  localparam int CNT_W = $clog2(MAX_SITES + 1);
  localparam int ENT_W = RESIDUE_BITS + 3 * COORD_BITS;

  pcpf_state_e state_q, state_d;

  logic [DIST_BITS-1:0]    max_dist_q;
  logic [SQ_BITS-1:0]      lim_q;
  logic [CNT_W-1:0]        site_count_q, site_count_d;
  logic                    taken_valid_q, taken_valid_d;
  logic [RESIDUE_BITS-1:0] taken_res_q;
  logic [CNT_W-1:0]        scan_n_q;
  logic [IDX_W-1:0]        rd_idx_q;
  logic                    rd_last;

  logic [RESIDUE_BITS-1:0]      item_res_q;
  logic signed [COORD_BITS-1:0] item_x_q, item_y_q, item_z_q;
  logic                         item_full_q;

  logic accept, new_site, full, store_site;
  logic rd_en, flush;

  logic [ENT_W-1:0] wdata, rdata;
  pcpf_tag_t        req;
  pcpf_hit_t        hit;
  logic [RESIDUE_BITS-1:0] hit_res;

  logic                    pend_valid_q, pend_valid_d;
  logic [RESIDUE_BITS-1:0] pend_res_q, pend_res_d;
  logic                    emit_d, emit_rl_d;
  logic [RESIDUE_BITS-1:0] emit_res_d;

  logic                    strobe_q;
  logic [RESIDUE_BITS-1:0] first_q, second_q;
  logic                    run_last_q, overflow_q;

  // accept and site qualification
  assign accept     = start && !busy;
  assign new_site   = accept && qualifies_i &&
                      !(taken_valid_q && (taken_res_q == residue_index_i));
  assign full       = site_count_q >= CNT_W'(MAX_SITES);
  assign store_site = new_site && !full;
  assign rd_last    = (CNT_W'(rd_idx_q) + CNT_W'(1)) == scan_n_q;

  // store bookkeeping, cleared after the end item
  always_comb begin
    site_count_d  = site_count_q;
    taken_valid_d = taken_valid_q;
    if (store_site) begin
      site_count_d = site_count_q + CNT_W'(1);
    end
    if (new_site) begin
      taken_valid_d = 1'b1;
    end
    if (accept && end_of_structure_i) begin
      site_count_d  = '0;
      taken_valid_d = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (new_site && (site_count_q != '0)) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (hit.valid && hit.last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    busy  = 1'b0;
    rd_en = 1'b0;
    flush = 1'b0;
    case (state_q)
      ST_IDLE:  busy = 1'b0;
      ST_SCAN: begin
        busy  = 1'b1;
        rd_en = 1'b1;
      end
      ST_DRAIN: busy = 1'b1;
      ST_FLUSH: begin
        busy  = 1'b1;
        flush = 1'b1;
      end
      default:  busy = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      max_dist_q    <= MAX_DIST_RESET;
      site_count_q  <= '0;
      taken_valid_q <= 1'b0;
      pend_valid_q  <= 1'b0;
      strobe_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      site_count_q  <= site_count_d;
      taken_valid_q <= taken_valid_d;
      pend_valid_q  <= pend_valid_d;
      strobe_q      <= emit_d;
      if (cfg_we_i) begin
        max_dist_q <= cfg_wdata_i;
      end
    end
  end

  // item payload and scan index
  always_ff @(posedge clk_i) begin
    lim_q <= SQ_BITS'(max_dist_q) * SQ_BITS'(max_dist_q);
    if (new_site) begin
      taken_res_q <= residue_index_i;
      item_res_q  <= residue_index_i;
      item_x_q    <= x_pos_i;
      item_y_q    <= y_pos_i;
      item_z_q    <= z_pos_i;
      item_full_q <= full;
      scan_n_q    <= site_count_q;
    end
    if (state_q == ST_SCAN) begin
      rd_idx_q <= rd_idx_q + IDX_W'(1);
    end else begin
      rd_idx_q <= '0;
    end
    pend_res_q <= pend_res_d;
    if (emit_d) begin
      first_q    <= emit_res_d;
      second_q   <= item_res_q;
      run_last_q <= emit_rl_d;
      overflow_q <= item_full_q;
    end
  end

  // site store
  assign wdata = {residue_index_i, x_pos_i, y_pos_i, z_pos_i};

  pcpf_site_mem #(
    .DEPTH (MAX_SITES),
    .WIDTH (ENT_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (store_site),
    .waddr_i (site_count_q[IDX_W-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (rd_idx_q),
    .rdata_o (rdata)
  );

  // distance test on each stored site
  assign req.valid = rd_en;
  assign req.last  = rd_en && rd_last;

  pcpf_dist_pipe #(
    .COORD_BITS   (COORD_BITS),
    .RESIDUE_BITS (RESIDUE_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .site_res_i (rdata[ENT_W-1 -: RESIDUE_BITS]),
    .site_x_i   (rdata[3*COORD_BITS-1 -: COORD_BITS]),
    .site_y_i   (rdata[2*COORD_BITS-1 -: COORD_BITS]),
    .site_z_i   (rdata[COORD_BITS-1:0]),
    .new_x_i    (item_x_q),
    .new_y_i    (item_y_q),
    .new_z_i    (item_z_q),
    .lim_i      (lim_q),
    .hit_o      (hit),
    .hit_res_o  (hit_res)
  );

  // one pair held back so the final one can be marked
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_res_d   = pend_res_q;
    emit_d       = 1'b0;
    emit_rl_d    = 1'b0;
    emit_res_d   = pend_res_q;
    if (accept) begin
      pend_valid_d = 1'b0;
    end
    if (hit.valid && hit.match) begin
      emit_d       = pend_valid_q;
      pend_valid_d = 1'b1;
      pend_res_d   = hit_res;
    end
    if (flush) begin
      emit_d       = pend_valid_q;
      emit_rl_d    = 1'b1;
      pend_valid_d = 1'b0;
    end
  end

  assign strobe_o         = strobe_q;
  assign first_residue_o  = first_q;
  assign second_residue_o = second_q;
  assign run_last_o       = run_last_q;
  assign overflow_o       = overflow_q;

  // pairs only come out of a scan
  a_strobe_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q |-> $past(state_q != ST_IDLE))
    else $error("pair emitted without a scan");

  // the marked pair closes the item
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_q && run_last_q |-> state_q == ST_IDLE)
    else $error("final pair while the scan is still open");

  // store never overfills
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    site_count_q <= CNT_W'(MAX_SITES))
    else $error("site count beyond capacity");

  // verdicts arrive only while a scan is under way
  a_hit_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("distance verdict outside a scan");

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import pcpf_pkg::*;

  localparam int RB            = RESIDUE_BITS_DEF;
  localparam int CB            = COORD_BITS_DEF;
  localparam int NSITES        = MAX_SITES_DEF;
  localparam int CLK_PERIOD    = 10;
  localparam int SETTLE_CYCLES = NSITES + 16;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int PHASE_SITES   = 6;

  // one atom record as it goes into the block
  typedef struct packed {
    logic [RB-1:0]        residue;
    logic                 qual;
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic signed [CB-1:0] z;
    logic                 eos;
  } atom_t;

  // one contact pair as it comes out of the block
  typedef struct packed {
    logic [RB-1:0] lo_res;
    logic [RB-1:0] hi_res;
    logic          run_last;
    logic          overflow;
  } pair_t;

  typedef enum logic {ROW_ATOM, ROW_DIST} row_kind_e;

  // directed row: an atom with an optional hand-written outcome, or a distance write
  typedef struct {
    row_kind_e      kind;
    atom_t          atom;
    logic [15:0]    max_d;
    bit             typed;
    int             npairs;
    logic [RB-1:0]  lo;
  } dir_row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic [RB-1:0]        residue_index_i;
  logic                 qualifies_i;
  logic signed [CB-1:0] x_pos_i;
  logic signed [CB-1:0] y_pos_i;
  logic signed [CB-1:0] z_pos_i;
  logic                 end_of_structure_i;
  logic                 cfg_we_i;
  logic [DIST_BITS-1:0] cfg_wdata_i;
  logic                 strobe_o;
  logic [RB-1:0]        first_residue_o;
  logic [RB-1:0]        second_residue_o;
  logic                 run_last_o;
  logic                 overflow_o;

  // travels with each item: outcome typed into the directed table
  logic                 row_typed;
  int                   row_npairs;
  logic [RB-1:0]        row_lo;

  // shadow of the block: site store, last taken residue, distance
  logic [RB-1:0]        site_res [NSITES];
  logic signed [CB-1:0] site_x [NSITES];
  logic signed [CB-1:0] site_y [NSITES];
  logic signed [CB-1:0] site_z [NSITES];
  int                   site_count = 0;
  bit                   taken_valid = 1'b0;
  logic [RB-1:0]        taken_res = '0;
  logic [DIST_BITS-1:0] max_dist_q = MAX_DIST_RESET;

  pair_t                pairs_due[$];
  int                   sites_taken = 0;
  int                   pair_errors = 0;
  int                   drive_dist = MAX_DIST_RESET;
  dir_row_t             dir_rows[$];

  pairwise_contact_pair_finder dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .residue_index_i    (residue_index_i),
    .qualifies_i        (qualifies_i),
    .x_pos_i            (x_pos_i),
    .y_pos_i            (y_pos_i),
    .z_pos_i            (z_pos_i),
    .end_of_structure_i (end_of_structure_i),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .strobe_o           (strobe_o),
    .first_residue_o    (first_residue_o),
    .second_residue_o   (second_residue_o),
    .run_last_o         (run_last_o),
    .overflow_o         (overflow_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic void report(input string msg);
    pair_errors++;
    if (pair_errors <= 10) $display("%s", msg);
  endfunction

  // compare a new site against the store, then store it if there is room and apply the clear
  function automatic void find_contacts(input atom_t a, input bit record);
    longint unsigned lim;
    longint dx, dy, dz;
    bit full;
    pair_t hit;
    pair_t hits[$];
    if (a.qual && !(taken_valid && taken_res == a.residue)) begin
      lim = longint'(max_dist_q) * longint'(max_dist_q);
      full = (site_count >= NSITES);
      taken_valid = 1'b1;
      taken_res = a.residue;
      sites_taken++;
      for (int k = 0; k < site_count; k++) begin
        dx = longint'($signed(a.x)) - longint'($signed(site_x[k]));
        dy = longint'($signed(a.y)) - longint'($signed(site_y[k]));
        dz = longint'($signed(a.z)) - longint'($signed(site_z[k]));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (dz < 0) dz = -dz;
        // any axis beyond 16 bits is out of reach for every threshold
        if (dx <= 65535 && dy <= 65535 && dz <= 65535 &&
            longint'(dx * dx + dy * dy + dz * dz) <= longint'(lim)) begin
          hit = '{site_res[k], a.residue, 1'b0, full};
          hits = {hits, hit};
        end
      end
      if (hits.size() > 0) hits[hits.size() - 1].run_last = 1'b1;
      if (record)
        pairs_due = {pairs_due, hits};
      if (!full) begin
        site_res[site_count] = a.residue;
        site_x[site_count] = a.x;
        site_y[site_count] = a.y;
        site_z[site_count] = a.z;
        site_count++;
      end
    end
    if (a.eos) begin
      site_count = 0;
      taken_valid = 1'b0;
      taken_res = '0;
    end
  endfunction

  // watch results, register writes and accepted items
  always @(posedge clk_i) begin : pair_monitor
    pair_t got;
    pair_t want;
    atom_t a;
    if (rst_ni) begin
      if (strobe_o) begin
        got = '{first_residue_o, second_residue_o, run_last_o, overflow_o};
        if (pairs_due.size() == 0) begin
          report($sformatf("unexpected pair %0d-%0d last=%0b ovf=%0b",
                           got.lo_res, got.hi_res, got.run_last, got.overflow));
        end else begin
          want = pairs_due.pop_front();
          if (got !== want)
            report($sformatf({"pair mismatch: expected %0d-%0d last=%0b ovf=%0b,",
                              " got %0d-%0d last=%0b ovf=%0b"},
                             want.lo_res, want.hi_res, want.run_last, want.overflow,
                             got.lo_res, got.hi_res, got.run_last, got.overflow));
        end
      end
      if (cfg_we_i) max_dist_q = cfg_wdata_i;
      if (start && !busy) begin
        a = '{residue_index_i, qualifies_i, x_pos_i, y_pos_i, z_pos_i,
              end_of_structure_i};
        find_contacts(a, !row_typed);
        if (row_typed && row_npairs == 1) begin
          want = '{row_lo, a.residue, 1'b1, 1'b0};
          pairs_due = {pairs_due, want};
        end
      end
    end
  end

  function automatic dir_row_t atom_row(input int res, input bit q, input int x,
                                        input int y, input int z, input bit eos,
                                        input bit typed, input int npairs,
                                        input int lo);
    dir_row_t r;
    r.kind = ROW_ATOM;
    r.atom = '{RB'(res), q, CB'(x), CB'(y), CB'(z), eos};
    r.max_d = '0;
    r.typed = typed;
    r.npairs = npairs;
    r.lo = RB'(lo);
    return r;
  endfunction

  function automatic dir_row_t dist_row(input int d);
    dir_row_t r;
    r.kind = ROW_DIST;
    r.atom = '0;
    r.max_d = 16'(d);
    r.typed = 1'b0;
    r.npairs = 0;
    r.lo = '0;
    return r;
  endfunction

  // present one item and hold it until the block takes it
  task automatic offer_atom(input atom_t a, input bit typed, input int npairs,
                            input logic [RB-1:0] lo);
    start <= 1'b1;
    residue_index_i <= a.residue;
    qualifies_i <= a.qual;
    x_pos_i <= a.x;
    y_pos_i <= a.y;
    z_pos_i <= a.z;
    end_of_structure_i <= a.eos;
    row_typed <= typed;
    row_npairs <= npairs;
    row_lo <= lo;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // random gap on the sending side
  task automatic sender_pause(input bit idle_on);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // write the distance once the block has gone quiet
  task automatic set_distance(input logic [15:0] d);
    start <= 1'b0;
    @(posedge clk_i);
    while (pairs_due.size() != 0 || busy) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_wdata_i <= d;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    drive_dist = d;
  endtask

  // well-formed structure: residues in order around one center, ends on eos
  task automatic send_structure(input int n_res, input int scale, input bit idle_on);
    logic [RB-1:0] res;
    logic signed [CB-1:0] cx, cy, cz;
    int n_atoms, q_at;
    bit dup, has_site;
    atom_t a;
    res = RB'($urandom);
    cx = CB'($urandom);
    cy = CB'($urandom);
    cz = CB'($urandom);
    for (int r = 0; r < n_res; r++) begin
      n_atoms = $urandom_range(1, 4);
      q_at = $urandom_range(0, n_atoms - 1);
      dup = ($urandom_range(0, 4) == 0);
      has_site = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < n_atoms; k++) begin
        a.residue = res;
        a.qual = has_site && (k == q_at || (dup && k > q_at));
        a.x = cx + CB'(int'($urandom_range(0, 2 * scale)) - scale);
        a.y = cy + CB'(int'($urandom_range(0, 2 * scale)) - scale);
        a.z = cz + CB'(int'($urandom_range(0, 2 * scale)) - scale);
        a.eos = (r == n_res - 1) && (k == n_atoms - 1);
        offer_atom(a, 1'b0, 0, '0);
        sender_pause(idle_on);
      end
      res = res + RB'($urandom_range(1, 3));
    end
  endtask

  // noise: random fields, some repeats of the previous residue
  task automatic send_noise(input int n, input bit idle_on);
    atom_t a;
    logic [RB-1:0] prev;
    prev = RB'($urandom);
    for (int k = 0; k < n; k++) begin
      a.residue = ($urandom_range(0, 3) == 0) ? prev : RB'($urandom);
      a.qual = 1'($urandom_range(0, 1));
      a.x = CB'($urandom);
      a.y = CB'($urandom);
      a.z = CB'($urandom);
      a.eos = ($urandom_range(0, 7) == 0);
      prev = a.residue;
      offer_atom(a, 1'b0, 0, '0);
      sender_pause(idle_on);
    end
  endtask

  // main sequence
  initial begin
    logic [15:0] phase_dist [6];
    int goal, scale, d;
    rst_ni = 1'b0;
    start = 1'b0;
    residue_index_i = '0;
    qualifies_i = 1'b0;
    x_pos_i = '0;
    y_pos_i = '0;
    z_pos_i = '0;
    end_of_structure_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    row_typed = 1'b0;
    row_npairs = 0;
    row_lo = '0;

    dir_rows = '{
      // reset distance of 2.5 angstrom
      atom_row(10, 0, 8388607, -8388608, 8388607, 0, 1, 0, 0),
      atom_row(10, 1, 0, 0, 0, 0, 1, 0, 0),
      atom_row(10, 1, 5, 5, 5, 0, 1, 0, 0),
      atom_row(11, 1, 640, 0, 0, 0, 1, 1, 10),
      atom_row(12, 1, 0, 641, 0, 0, 1, 0, 0),
      atom_row(13, 1, 0, 0, -640, 0, 1, 1, 10),
      atom_row(10, 1, 0, 0, 1, 0, 0, 0, 0),
      atom_row(14, 1, 384, 384, 384, 0, 0, 0, 0),
      atom_row(15, 0, 0, 0, 0, 1, 1, 0, 0),
      atom_row(15, 1, -8388608, -8388608, -8388608, 0, 1, 0, 0),
      atom_row(16, 1, 8388607, 8388607, 8388607, 0, 1, 0, 0),
      atom_row(65535, 0, -1, -1, -1, 1, 1, 0, 0),
      // widest distance: axis difference at and past 16 bits
      dist_row(65535),
      atom_row(21, 1, 0, 0, 0, 0, 1, 0, 0),
      atom_row(22, 1, 65535, 0, 0, 0, 1, 1, 21),
      atom_row(23, 1, -65536, 0, 0, 0, 1, 0, 0),
      atom_row(24, 1, 0, 65535, 65535, 0, 1, 0, 0),
      atom_row(65535, 1, 1, 1, 1, 1, 0, 0, 0),
      // zero distance: only coincident sites pair
      dist_row(0),
      atom_row(0, 1, -1, -1, -1, 0, 1, 0, 0),
      atom_row(1, 1, -1, -1, -1, 0, 1, 1, 0),
      atom_row(2, 1, -1, -1, 0, 0, 1, 0, 0),
      atom_row(3, 0, 0, 0, 0, 1, 1, 0, 0)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_DIST) begin
        set_distance(dir_rows[k].max_d);
      end else begin
        offer_atom(dir_rows[k].atom, dir_rows[k].typed, dir_rows[k].npairs,
                   dir_rows[k].lo);
        sender_pause(1'b1);
      end
    end

    // random phases, one distance each; the last one runs without gaps
    phase_dist = '{16'd640, 16'd1, 16'hFFFF, 16'($urandom_range(2, 4000)), 16'd0,
                   16'($urandom_range(2, 65534))};
    for (int p = 0; p < 6; p++) begin
      set_distance(phase_dist[p]);
      // overfill the store so that late sites are compared but not kept
      if (phase_dist[p] == 16'hFFFF) send_structure(80, 64, 1'b1);
      goal = sites_taken + PHASE_SITES;
      while (sites_taken < goal) begin
        d = drive_dist;
        case ($urandom_range(0, 2))
          0: scale = d / 2 + 1;
          1: scale = d + 1;
          default: scale = 2 * d + 2;
        endcase
        if ($urandom_range(0, 4) == 0)
          send_noise($urandom_range(1, 6), p != 5);
        else
          send_structure($urandom_range(2, 12), scale, p != 5 && $urandom_range(0, 3) != 0);
      end
    end

    // drain and finish
    start <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && (pairs_due.size() != 0 || busy); k++)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (pairs_due.size() != 0)
      report($sformatf("%0d pairs never arrived", pairs_due.size()));
    if (pair_errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // hard limit on the run
  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
